/* src/tilc_pkg.sv */
package tilc_pkg;

  typedef enum logic [1:0] {
    VERDICT_EXECUTE    = 2'd0,
    VERDICT_UNDEFINED  = 2'd1,
    VERDICT_BREAKPOINT = 2'd2
  } verdict_t;

  function automatic logic spc(input logic [3:0] r);
    return (r == 4'd13) || (r == 4'd15);
  endfunction

  function automatic logic is_cmp_op(input logic [3:0] op);
    return (op == 4'd0) || (op == 4'd4) || (op == 4'd8) || (op == 4'd13);
  endfunction

  // any list bit below position idx
  function automatic logic lower_set(input logic [15:0] list, input logic [3:0] idx);
    logic [15:0] mask;
    mask = (16'd1 << idx) - 16'd1;
    return (idx != 4'd0) && ((list & mask) != 16'd0);
  endfunction

  function automatic logic is_mem_op(input logic [15:0] op);
    return op == 16'hf800 || op == 16'hf810 || op == 16'hf820 || op == 16'hf830 ||
           op == 16'hf840 || op == 16'hf850 || op == 16'hf880 || op == 16'hf890 ||
           op == 16'hf8a0 || op == 16'hf8b0 || op == 16'hf8c0 || op == 16'hf8d0 ||
           op == 16'hf910 || op == 16'hf930 || op == 16'hf990 || op == 16'hf9b0;
  endfunction

endpackage

/* src/tilc_check.sv */
module tilc_check (
  input  logic [15:0]       a,
  input  logic [15:0]       b,
  input  logic              wide,
  input  logic [7:0]        it,
  output tilc_pkg::verdict_t verdict
);

  // narrow checks
  logic n_bkpt, n_badit, n_badcps, n_badregs, n_itforbid, n_wpc, n_stm_bad;
  logic [1:0] n_op;
  logic [3:0] n_rd;
  logic [2:0] n_rn;

  always_comb begin
    n_bkpt   = (a & 16'hff00) == 16'hbe00;
    n_badit  = (a & 16'hff00) == 16'hbf00 && a[3:0] != 4'd0 &&
               (a[7:4] >= 4'd14 || it != 8'd0);
    n_badcps = (a & 16'hffe0) == 16'hb660 && (a[3] || a[2:0] == 3'd0 || a[2]);
    n_rn      = a[10:8];
    n_stm_bad = (a & 16'hf000) == 16'hc000 &&
                (a[7:0] == 8'd0 ||
                 (!a[11] && a[{1'b0, n_rn}] &&
                  tilc_pkg::lower_set({8'd0, a[7:0]}, {1'b0, n_rn})));
    n_badregs = (((a & 16'hfe00) == 16'hb400 || (a & 16'hfe00) == 16'hbc00) &&
                 (a & 16'h01ff) == 16'd0) || n_stm_bad ||
                ((a & 16'hff00) == 16'h4700 && a[6:3] == 4'd15);
    n_itforbid = ((a & 16'hff00) == 16'hbf00 && a[3:0] != 4'd0) ||
                 (a & 16'hf500) == 16'hb100 || (a & 16'hffe0) == 16'hb660 ||
                 (a & 16'hff00) == 16'hdf00;
    n_op = a[9:8];
    n_rd = {a[7], a[2:0]};
    if ((a & 16'hfc00) == 16'h4400) begin
      n_wpc = n_op == 2'd3 || ((n_op == 2'd0 || n_op == 2'd2) && n_rd == 4'd15);
    end else if ((a & 16'hfe00) == 16'hbc00 && a[8]) begin
      n_wpc = 1'b1;
    end else begin
      n_wpc = (a & 16'hf000) == 16'hd000 || (a & 16'hf800) == 16'he000;
    end
  end

  // wide checks
  logic [15:0] op16;
  logic [3:0]  rn, rd8, rt12, rm;
  logic        s_bit;
  logic [3:0]  dpop;
  logic        b_dpimm, b_dpsh, b_plain, b_bf, b_md, b_dual, b_multi, b_excl;
  logic        b_mem, b_sys, b_wmov, w_wpc;
  logic [11:0] imm;
  logic [4:0]  lsb, wdt;
  logic [5:0]  bf_sum;
  logic        ins, p, u, w, l, word, indexed;
  logic [4:0]  pop;
  logic [3:0]  sysop;
  logic [15:0] m;

  always_comb begin
    op16  = a & 16'hfff0;
    rn    = a[3:0];
    rd8   = b[11:8];
    rt12  = b[15:12];
    rm    = b[3:0];
    s_bit = a[4];
    dpop  = a[8:5];
    m     = a & 16'hfbf0;

    imm = {a[10], b[14:12], b[7:0]};
    b_dpimm = (a & 16'hfa00) == 16'hf000 && !b[15] &&
              (((imm & 12'hc00) == 12'd0 && (imm & 12'h300) != 12'd0 && imm[7:0] == 8'd0) ||
               (rd8 == 4'd15 && (!s_bit || !tilc_pkg::is_cmp_op(dpop))) ||
               (rn == 4'd15 && !(dpop == 4'd2 || dpop == 4'd3)) || rd8 == 4'd13);

    b_dpsh = (a & 16'hfe00) == 16'hea00 && !b[15] &&
             (tilc_pkg::spc(rm) || rd8 == 4'd13 ||
              (rd8 == 4'd15 && (!s_bit || !tilc_pkg::is_cmp_op(dpop))) ||
              (tilc_pkg::spc(rn) && !(rn == 4'd15 && (dpop == 4'd2 || dpop == 4'd3))));

    if ((a & 16'hff80) == 16'hfa00 && (b & 16'hf0c0) == 16'hf000) begin
      b_plain = tilc_pkg::spc(rn) || tilc_pkg::spc(rd8) || tilc_pkg::spc(rm);
    end else if (((a & 16'hfff0) == 16'hfab0 && (b & 16'hf0f0) == 16'hf080) ||
                 ((a & 16'hfff0) == 16'hfa90 && (b & 16'hf0f0) == 16'hf0a0)) begin
      b_plain = tilc_pkg::spc(rn) || tilc_pkg::spc(rd8);
    end else if (((a & 16'hfbd0) == 16'hf300 || (a & 16'hfbd0) == 16'hf380) && !b[15]) begin
      b_plain = tilc_pkg::spc(rn) || tilc_pkg::spc(rd8);
    end else begin
      b_plain = 1'b0;
    end

    lsb    = {b[14:12], b[7:6]};
    wdt    = b[4:0];
    bf_sum = {1'b0, lsb} + {1'b0, wdt} + 6'd1;
    ins    = op16 == 16'hf360;
    if ((op16 == 16'hf360 || op16 == 16'hf340 || op16 == 16'hf3c0) && !b[15]) begin
      if (tilc_pkg::spc(rd8) || (!ins && tilc_pkg::spc(rn)) || (ins && rn == 4'd13))
        b_bf = 1'b1;
      else if (ins) b_bf = wdt < lsb;
      else b_bf = bf_sum > 6'd32;
    end else begin
      b_bf = 1'b0;
    end

    if ((op16 == 16'hfbb0 || op16 == 16'hfb90) && (b & 16'hf0f0) == 16'hf0f0) begin
      b_md = tilc_pkg::spc(rn) || tilc_pkg::spc(rd8) || tilc_pkg::spc(rm);
    end else if (op16 == 16'hfb00 && b[7:4] == 4'd0) begin
      b_md = tilc_pkg::spc(rn) || tilc_pkg::spc(rd8) || tilc_pkg::spc(rm) || rt12 == 4'd13;
    end else if ((op16 == 16'hfba0 || op16 == 16'hfb80 || op16 == 16'hfbe0 ||
                  op16 == 16'hfbc0) && b[7:4] == 4'd0) begin
      b_md = tilc_pkg::spc(rn) || tilc_pkg::spc(rt12) || tilc_pkg::spc(rd8) ||
             tilc_pkg::spc(rm) || rt12 == rd8;
    end else begin
      b_md = 1'b0;
    end

    p = a[8]; u = a[7]; w = a[5]; l = a[4];
    b_dual = (a & 16'hfe40) == 16'he840 && (p || w) &&
             (tilc_pkg::spc(rt12) || tilc_pkg::spc(rd8) || rt12 == rd8 ||
              (rn == 4'd15 && !(l && p && u && !w)) ||
              (w && (rn == rt12 || rn == rd8)));

    pop = 5'd0;
    for (int i = 0; i < 16; i++) pop = pop + {4'd0, b[i]};
    if ((a & 16'hffc0) == 16'he900 || (a & 16'hffd0) == 16'he880 ||
        (a & 16'hffd0) == 16'he890) begin
      if (rn == 4'd15 || b[13] || pop < 5'd2 || (!l && b[15]) || (l && b[15] && b[14]))
        b_multi = 1'b1;
      else if (!w || !b[rn]) b_multi = 1'b0;
      else b_multi = l || tilc_pkg::lower_set(b, rn);
    end else begin
      b_multi = 1'b0;
    end

    if (op16 == 16'he850 && b[11:8] == 4'hf) begin
      b_excl = tilc_pkg::spc(rn) || tilc_pkg::spc(rt12);
    end else if (op16 == 16'he840 && !b[11]) begin
      b_excl = tilc_pkg::spc(rn) || tilc_pkg::spc(rt12) || tilc_pkg::spc(rd8) ||
               rd8 == rn || rd8 == rt12;
    end else if (op16 == 16'he8d0 && (b & 16'h0f0f) == 16'h0f0f) begin
      b_excl = tilc_pkg::spc(rn) || tilc_pkg::spc(rt12);
    end else if (op16 == 16'he8c0 && b[11:8] == 4'hf) begin
      b_excl = tilc_pkg::spc(rn) || tilc_pkg::spc(rt12) || tilc_pkg::spc(rm) ||
               rm == rn || rm == rt12;
    end else begin
      b_excl = 1'b0;
    end

    word    = op16[6];
    indexed = op16 == 16'hf800 || op16 == 16'hf810 || op16 == 16'hf820 ||
              op16 == 16'hf830 || op16 == 16'hf840 || op16 == 16'hf850 ||
              op16 == 16'hf910 || op16 == 16'hf930;
    if (!tilc_pkg::is_mem_op(op16)) b_mem = 1'b0;
    else if (rt12 == 4'd13 || (!op16[4] && rt12 == 4'd15)) b_mem = 1'b1;
    else if (!indexed) b_mem = rn == 4'd15 && !op16[4];
    else if (rn == 4'd15) b_mem = 1'b1;
    else if ((b & 16'h0fc0) == 16'd0) b_mem = tilc_pkg::spc(rm) || (rt12 == 4'd15 && !word);
    else if (b[11:8] == 4'he) b_mem = tilc_pkg::spc(rt12);
    else if (!b[11]) b_mem = 1'b1;
    else b_mem = (!b[10] && !b[8]) || (b[8] && rn == rt12) || (rt12 == 4'd15 && !word);

    sysop = b[7:4];
    if (a == 16'hf3ef && b[15:12] == 4'h8) b_sys = tilc_pkg::spc(rd8);
    else if (op16 == 16'hf380 && b[15:8] == 8'h88) b_sys = tilc_pkg::spc(rn);
    else if (a == 16'hf3bf && (b & 16'hff0f) == 16'h8f0f)
      b_sys = sysop != 4'd2 && sysop != 4'd4 && sysop != 4'd5 && sysop != 4'd6;
    else b_sys = 1'b0;

    if (m == 16'hf240 || m == 16'hf2c0) b_wmov = tilc_pkg::spc(rd8);
    else if ((m == 16'hf200 || m == 16'hf2a0) && !b[15]) b_wmov = rd8 == 4'd15;
    else if (op16 == 16'he8d0 && (b & 16'hffe0) == 16'hf000) b_wmov = tilc_pkg::spc(rm);
    else b_wmov = 1'b0;

    if ((a & 16'hf800) == 16'hf000 && ((b & 16'hd000) == 16'hd000 ||
        (b & 16'hd000) == 16'h9000 || ((b & 16'hd000) == 16'h8000 && a[9:6] < 4'd14)))
      w_wpc = 1'b1;
    else if (op16 == 16'he8d0 && (b & 16'hffe0) == 16'hf000) w_wpc = 1'b1;
    else if (((a & 16'hffd0) == 16'he890 || ((a & 16'hffc0) == 16'he900 && a[4])) && b[15])
      w_wpc = 1'b1;
    else if (tilc_pkg::is_mem_op(op16) && op16[4] && rt12 == 4'd15) w_wpc = 1'b1;
    else if ((a & 16'hfa00) == 16'hf000 || (a & 16'hfe00) == 16'hea00)
      w_wpc = rd8 == 4'd15 && (!s_bit || !tilc_pkg::is_cmp_op(dpop));
    else if (m == 16'hf200 || m == 16'hf2a0 || m == 16'hf240 || m == 16'hf2c0)
      w_wpc = rd8 == 4'd15;
    else w_wpc = 1'b0;

    if (wide) begin
      if (b_dpimm || b_dpsh || b_plain || b_bf || b_md || b_dual || b_multi || b_excl ||
          b_mem || b_sys || b_wmov)
        verdict = tilc_pkg::VERDICT_UNDEFINED;
      else if (it != 8'd0 && it[2:0] != 3'd0 && w_wpc)
        verdict = tilc_pkg::VERDICT_UNDEFINED;
      else verdict = tilc_pkg::VERDICT_EXECUTE;
    end else begin
      if (n_bkpt) verdict = tilc_pkg::VERDICT_BREAKPOINT;
      else if (n_badit || n_badcps || n_badregs) verdict = tilc_pkg::VERDICT_UNDEFINED;
      else if (it == 8'd0) verdict = tilc_pkg::VERDICT_EXECUTE;
      else if (n_itforbid || (it[2:0] != 3'd0 && n_wpc))
        verdict = tilc_pkg::VERDICT_UNDEFINED;
      else verdict = tilc_pkg::VERDICT_EXECUTE;
    end
  end

endmodule

/* src/thumb_instruction_legality_check.sv */
// out_valid follows a start transfer through the input and result registers.
// Throughput: one instruction per cycle; busy is always low.
// The check is a single combinational pass of masks, compares and a 16-bit popcount.
// Reset (rst_n low, synchronous) clears the valid flags; the receiver cannot stall.
module thumb_instruction_legality_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_first_halfword,
  input  logic [15:0] in_second_halfword,
  input  logic        in_is_wide,
  input  logic [7:0]  in_cond_block_state,
  output logic        out_valid,
  output logic [1:0]  out_verdict
);

  logic        vld_r;
  logic [15:0] a_r, b_r;
  logic        wide_r;
  logic [7:0]  it_r;
  logic        out_valid_r;
  logic [1:0]  verdict_r;
  tilc_pkg::verdict_t verdict_nxt;

  tilc_check u_check (
    .a       (a_r),
    .b       (b_r),
    .wide    (wide_r),
    .it      (it_r),
    .verdict (verdict_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= start;
      out_valid_r <= vld_r;
    end
    a_r       <= in_first_halfword;
    b_r       <= in_second_halfword;
    wide_r    <= in_is_wide;
    it_r      <= in_cond_block_state;
    verdict_r <= verdict_nxt;
  end

  assign busy        = 1'b0;
  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

endmodule
